// File: src/vn3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vn3_pkg: shared constants for the 3D vector normalizer
// Default widths and the fixed fraction width of the length result.
// ----------------------------------------------------------------------------
package vn3_pkg;

  // Default component width of the input vector.
  localparam int unsigned COMP_WIDTH_DEF = 16;

  // Default fraction width of the unit components (Q2.F).
  localparam int unsigned UNIT_FRAC_DEF = 14;

  // Fraction bits carried by the length result.
  localparam int unsigned LEN_FRAC_BITS = 8;

endpackage
`default_nettype wire

// File: src/vn3_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vn3_sqrt: pipelined integer square root
// Computes floor(sqrt(sum * 2^16)), one root bit per register stage, and
// carries a side payload alongside each request.
// ----------------------------------------------------------------------------
module vn3_sqrt #(
  parameter int unsigned CompWidth = vn3_pkg::COMP_WIDTH_DEF,
  parameter int unsigned PayWidth  = 1
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [2*CompWidth-1:0]                     sum_i,
  input  logic [PayWidth-1:0]                        pay_i,
  output logic                                       valid_o,
  output logic [CompWidth+vn3_pkg::LEN_FRAC_BITS-1:0] root_o,
  output logic [PayWidth-1:0]                        pay_o
);
  import vn3_pkg::*;

  localparam int unsigned LenW = CompWidth + LEN_FRAC_BITS;
  localparam int unsigned RadW = 2 * LenW;
  localparam int unsigned RemW = LenW + 3;

  logic                v_q    [LenW];
  logic [RemW-1:0]     rem_q  [LenW];
  logic [LenW-1:0]     root_q [LenW];
  logic [RadW-1:0]     rad_q  [LenW];
  logic [PayWidth-1:0] pay_q  [LenW];

  for (genvar k = 0; k < LenW; k++) begin : g_stage
    logic                v_in;
    logic [RemW-1:0]     rem_in;
    logic [LenW-1:0]     root_in;
    logic [RadW-1:0]     rad_in;
    logic [PayWidth-1:0] pay_in;
    logic [RemW-1:0]     rem_x;
    logic [RemW-1:0]     trial;
    logic                ge;

    // Stage inputs come from the port at the head and the prior stage after.
    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = {sum_i, {(2 * LEN_FRAC_BITS){1'b0}}};
      assign pay_in  = pay_i;
    end else begin : g_body
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign pay_in  = pay_q[k-1];
    end

    // Bring down the next bit pair and try the subtraction.
    assign rem_x = {rem_in[RemW-3:0], rad_in[RadW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (rem_x >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_x - trial) : rem_x;
        root_q[k] <= {root_in[LenW-2:0], ge};
        rad_q[k]  <= {rad_in[RadW-3:0], 2'b00};
        pay_q[k]  <= pay_in;
      end
    end
  end

  assign valid_o = v_q[LenW-1];
  assign root_o  = root_q[LenW-1];
  assign pay_o   = pay_q[LenW-1];

endmodule
`default_nettype wire

// File: src/vn3_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vn3_div: three-lane pipelined restoring divider
// Each lane computes floor(mag * 2^(F+8) / len), one quotient bit per stage.
// ----------------------------------------------------------------------------
module vn3_div #(
  parameter int unsigned CompWidth    = vn3_pkg::COMP_WIDTH_DEF,
  parameter int unsigned UnitFracBits = vn3_pkg::UNIT_FRAC_DEF,
  parameter int unsigned PayWidth     = 1
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [CompWidth+vn3_pkg::LEN_FRAC_BITS-1:0] len_i,
  input  logic [2:0][CompWidth-1:0]                  mag_i,
  input  logic [PayWidth-1:0]                        pay_i,
  output logic                                       valid_o,
  output logic [CompWidth+vn3_pkg::LEN_FRAC_BITS-1:0] len_o,
  output logic [2:0][UnitFracBits:0]                 quo_o,
  output logic [PayWidth-1:0]                        pay_o
);
  import vn3_pkg::*;

  localparam int unsigned LenW = CompWidth + LEN_FRAC_BITS;
  localparam int unsigned NumStages = UnitFracBits + 1;

  logic                       v_q   [NumStages];
  logic [LenW-1:0]            len_q [NumStages];
  logic [2:0][LenW-1:0]       r_q   [NumStages];
  logic [2:0][UnitFracBits:0] q_q   [NumStages];
  logic [PayWidth-1:0]        pay_q [NumStages];

  for (genvar j = 0; j < NumStages; j++) begin : g_stage
    logic                       v_in;
    logic [LenW-1:0]            len_in;
    logic [2:0][LenW:0]         dvd;
    logic [2:0][UnitFracBits:0] q_in;
    logic [PayWidth-1:0]        pay_in;
    logic [2:0]                 ge;
    logic [2:0][LenW:0]         diff;

    // The first stage divides mag * 2^8, later stages shift the remainder.
    if (j == 0) begin : g_head
      assign v_in   = valid_i;
      assign len_in = len_i;
      assign pay_in = pay_i;
      assign q_in   = '0;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign dvd[l] = {1'b0, mag_i[l], {LEN_FRAC_BITS{1'b0}}};
      end
    end else begin : g_body
      assign v_in   = v_q[j-1];
      assign len_in = len_q[j-1];
      assign pay_in = pay_q[j-1];
      assign q_in   = q_q[j-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign dvd[l] = {r_q[j-1][l], 1'b0};
      end
    end

    // One trial subtraction per lane.
    for (genvar l = 0; l < 3; l++) begin : g_cmp
      assign ge[l]   = (dvd[l] >= {1'b0, len_in});
      assign diff[l] = ge[l] ? (dvd[l] - {1'b0, len_in}) : dvd[l];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[j] <= len_in;
        pay_q[j] <= pay_in;
        for (int l = 0; l < 3; l++) begin
          r_q[j][l] <= diff[l][LenW-1:0];
          q_q[j][l] <= {q_in[l][UnitFracBits-1:0], ge[l]};
        end
      end
    end
  end

  assign valid_o = v_q[NumStages-1];
  assign len_o   = len_q[NumStages-1];
  assign quo_o   = q_q[NumStages-1];
  assign pay_o   = pay_q[NumStages-1];

endmodule
`default_nettype wire

// File: src/vector_normalize_3d_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_normalize_3d_core: 3D vector length and unit vector
// Returns floor(sqrt(x^2+y^2+z^2) * 2^8) and the three components divided by
// it in Q2.F, truncated toward zero and saturated; a zero vector flags.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, x/y/z_comp_i     | request in
//   out     | out_valid_o, out_ready_i, unit_x/y/z_o,  | result out
//           | vec_length_o, zero_length_o              |
//
// One request enters per cycle while in_ready_o is high. The pipeline runs
// through the magnitude, squares and sum registers, the square-root stages,
// the divider stages and the output register. Reset clears only the valid
// bits. When a result waits on the output, the whole pipeline holds and
// in_ready_o drops.
// ----------------------------------------------------------------------------
module vector_normalize_3d_core #(
  parameter int unsigned CompWidth    = vn3_pkg::COMP_WIDTH_DEF,
  parameter int unsigned UnitFracBits = vn3_pkg::UNIT_FRAC_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic signed [CompWidth-1:0]                 x_comp_i,
  input  logic signed [CompWidth-1:0]                 y_comp_i,
  input  logic signed [CompWidth-1:0]                 z_comp_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic signed [UnitFracBits+1:0]              unit_x_o,
  output logic signed [UnitFracBits+1:0]              unit_y_o,
  output logic signed [UnitFracBits+1:0]              unit_z_o,
  output logic [CompWidth+vn3_pkg::LEN_FRAC_BITS-1:0] vec_length_o,
  output logic                                        zero_length_o
);
  import vn3_pkg::*;

  localparam int unsigned LenW  = CompWidth + LEN_FRAC_BITS;
  localparam int unsigned UnitW = UnitFracBits + 2;
  localparam int unsigned SqPay = 3 * CompWidth + 4;
  localparam logic [UnitFracBits:0] QuoFull = {1'b1, {UnitFracBits{1'b0}}};
  localparam logic signed [UnitW-1:0] UnitFull = {2'b01, {UnitFracBits{1'b0}}};

  logic en;

  // The pipeline advances whenever the output register is free or drains.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 0: magnitudes and signs.
  logic [2:0][CompWidth-1:0] comp_in;
  logic                      v0_q;
  logic [2:0][CompWidth-1:0] mag0_q;
  logic [2:0]                neg0_q;

  assign comp_in = {z_comp_i, y_comp_i, x_comp_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        neg0_q[l] <= comp_in[l][CompWidth-1];
        mag0_q[l] <= comp_in[l][CompWidth-1] ? (~comp_in[l] + 1'b1) : comp_in[l];
      end
    end
  end

  // Stage 1: squares.
  logic                        v1_q;
  logic [2:0][CompWidth-1:0]   mag1_q;
  logic [2:0]                  neg1_q;
  logic [2:0][2*CompWidth-1:0] sq1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag1_q <= mag0_q;
      neg1_q <= neg0_q;
      for (int l = 0; l < 3; l++) begin
        sq1_q[l] <= mag0_q[l] * mag0_q[l];
      end
    end
  end

  // Stage 2: sum of squares; it stays below 2^(2*CompWidth).
  logic [2*CompWidth+1:0]    sum_w;
  logic                      v2_q;
  logic [2*CompWidth-1:0]    sum2_q;
  logic [2:0][CompWidth-1:0] mag2_q;
  logic [2:0]                neg2_q;
  logic                      zero2_q;

  assign sum_w = {2'b00, sq1_q[0]} + {2'b00, sq1_q[1]} + {2'b00, sq1_q[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum2_q  <= sum_w[2*CompWidth-1:0];
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      zero2_q <= (sum_w == '0);
    end
  end

  // Square root, with magnitudes, signs and the zero flag alongside.
  logic                      sq_valid;
  logic [LenW-1:0]           sq_root;
  logic [SqPay-1:0]          sq_pay;
  logic [2:0][CompWidth-1:0] sq_mag;
  logic [3:0]                sq_side;

  vn3_sqrt #(
    .CompWidth (CompWidth),
    .PayWidth  (SqPay)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .sum_i   (sum2_q),
    .pay_i   ({mag2_q, neg2_q, zero2_q}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .pay_o   (sq_pay)
  );

  assign {sq_mag, sq_side} = sq_pay;

  // Division of each magnitude by the length.
  logic                       dv_valid;
  logic [LenW-1:0]            dv_len;
  logic [2:0][UnitFracBits:0] dv_quo;
  logic [3:0]                 dv_side;
  logic [2:0]                 dv_neg;
  logic                       dv_zero;

  vn3_div #(
    .CompWidth    (CompWidth),
    .UnitFracBits (UnitFracBits),
    .PayWidth     (4)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .len_i   (sq_root),
    .mag_i   (sq_mag),
    .pay_i   (sq_side),
    .valid_o (dv_valid),
    .len_o   (dv_len),
    .quo_o   (dv_quo),
    .pay_o   (dv_side)
  );

  assign {dv_neg, dv_zero} = dv_side;

  // Output stage: saturate, apply the sign and force the zero-vector result.
  logic [2:0][UnitW-1:0] unit_d;
  logic [2:0][UnitW-1:0] unit_q;
  logic [LenW-1:0]       len_q;
  logic                  zero_q;
  logic                  out_valid_q;

  always_comb begin
    logic [UnitFracBits:0] sat;
    for (int l = 0; l < 3; l++) begin
      sat = (dv_quo[l] > QuoFull) ? QuoFull : dv_quo[l];
      if (dv_zero) begin
        unit_d[l] = '0;
      end else if (dv_neg[l]) begin
        unit_d[l] = -{1'b0, sat};
      end else begin
        unit_d[l] = {1'b0, sat};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      unit_q <= unit_d;
      len_q  <= dv_zero ? '0 : dv_len;
      zero_q <= dv_zero;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign unit_x_o      = unit_q[0];
  assign unit_y_o      = unit_q[1];
  assign unit_z_o      = unit_q[2];
  assign vec_length_o  = len_q;
  assign zero_length_o = zero_q;

  // A zero vector gives all-zero results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |->
      unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0 && vec_length_o == '0)
    else $error("zero vector result not cleared");

  // A nonzero vector has a nonzero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_length_o |-> vec_length_o != '0)
    else $error("nonzero vector with zero length");

  // Unit components stay within full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> unit_x_o <= UnitFull && unit_x_o >= -UnitFull &&
                    unit_y_o <= UnitFull && unit_y_o >= -UnitFull &&
                    unit_z_o <= UnitFull && unit_z_o >= -UnitFull)
    else $error("unit component beyond full scale");

  // The input is held off only while a result waits on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

endmodule
`default_nettype wire
